FILE: design/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg: shared types and constants for the hsv to rgb converter
// Fixed point format, request and result structs, sector codes.
// ----------------------------------------------------------------------------
package h2r_pkg;

	localparam int FRAC_BITS = 16;
	localparam int HUE_W     = FRAC_BITS + 5;
	localparam int UNIT_W    = FRAC_BITS + 1;
	localparam int CH_W      = 8;
	localparam int SEC_W     = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [UNIT_W-1:0] ONE = UNIT_W'(1) << FRAC_BITS;

	// hue sextants
	localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
	localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
	localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
	localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
	localparam logic [SEC_W-1:0] SEC_BM = 3'd4;

	typedef struct packed {
		logic signed [HUE_W-1:0] hue;
		logic [UNIT_W-1:0]       saturation;
		logic [UNIT_W-1:0]       brightness;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [SEC_W-1:0]  sector;
		logic [UNIT_W-1:0] w;
		logic [UNIT_W-1:0] s;
		logic [UNIT_W-1:0] v;
	} cls_t;

endpackage

FILE: design/h2r_front.sv
// ----------------------------------------------------------------------------
// h2r_front: request intake and hue classification
// Folds hue into [0, 1), clamps saturation and value, finds the sextant and
// the triangle weight, and registers the classified request.
// ----------------------------------------------------------------------------
module h2r_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hsv_valid,
	output logic          hsv_stall,
	input  h2r_pkg::hsv_t hsv,
	output h2r_pkg::cls_t cls,
	output logic          cls_valid,
	input  logic          cls_ready
);
	import h2r_pkg::*;

	logic                   valid_s1;
	cls_t                   cls_s1;
	logic                   take;
	logic                   wrap;
	logic [FRAC_BITS-1:0]   h;
	logic [FRAC_BITS+2:0]   t;
	logic [UNIT_W-1:0]      r2;
	cls_t                   cls_d;

	assign hsv_stall = valid_s1 && !cls_ready;
	assign take      = hsv_valid && !hsv_stall;

	always_comb begin
		// hue above one folds to one minus its fraction; the other cases keep
		// the low fraction bits, and exactly one lands on zero
		wrap = !hsv.hue[HUE_W-1] && (hsv.hue[HUE_W-2:0] > (HUE_W-1)'(ONE));
		h = wrap ? (~hsv.hue[FRAC_BITS-1:0] + FRAC_BITS'(1)) : hsv.hue[FRAC_BITS-1:0];
		t = ((FRAC_BITS+3)'(h) << 2) + ((FRAC_BITS+3)'(h) << 1);
		r2 = t[FRAC_BITS:0];
		cls_d.sector = t[FRAC_BITS+2:FRAC_BITS];
		cls_d.w = r2[FRAC_BITS] ? UNIT_W'({1'b0, ONE, 1'b0} - {2'b0, r2}) : r2;
		cls_d.s = (hsv.saturation > ONE) ? ONE : hsv.saturation;
		cls_d.v = (hsv.brightness > ONE) ? ONE : hsv.brightness;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hsv_stall) begin
			valid_s1 <= hsv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1 <= cls_d;
		end
	end

	assign cls       = cls_s1;
	assign cls_valid = valid_s1;

endmodule

FILE: design/h2r_queue.sv
// ----------------------------------------------------------------------------
// h2r_queue: short request queue between front and back
// Register based first-in first-out buffer with a fill count.
// ----------------------------------------------------------------------------
module h2r_queue #(
	parameter int DEPTH = h2r_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  h2r_pkg::cls_t wr_data,
	input  logic          wr_valid,
	output logic          wr_ready,
	output h2r_pkg::cls_t rd_data,
	output logic          rd_valid,
	input  logic          rd_ready
);
	import h2r_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cls_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("queue count missed a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == CNT_W'(DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

endmodule

FILE: design/h2r_back.sv
// ----------------------------------------------------------------------------
// h2r_back: color arithmetic pipeline
// Chroma, middle channel and offset, sector ordering and scaling to bytes
// over three registered stages with per-stage flow control.
// ----------------------------------------------------------------------------
module h2r_back (
	input  logic          clk,
	input  logic          arst_n,
	input  h2r_pkg::cls_t cls,
	input  logic          cls_valid,
	output logic          cls_ready,
	output h2r_pkg::rgb_t rgb,
	output logic          rgb_valid,
	input  logic          rgb_stall
);
	import h2r_pkg::*;

	logic                valid_s1, valid_s2, valid_s3;
	logic                rdy1, rdy2, rdy3;
	logic [SEC_W-1:0]    sec_s1, sec_s2;
	logic [UNIT_W-1:0]   c_s1, w_s1, v_s1;
	logic [UNIT_W-1:0]   c_s2, x_s2, m_s2;
	rgb_t                rgb_s3;
	logic [2*UNIT_W-1:0] prod_c, prod_x;
	logic [UNIT_W-1:0]   hi, mid, lo;
	logic [UNIT_W-1:0]   r_val, g_val, b_val;

	function automatic logic [CH_W-1:0] to_byte(input logic [UNIT_W-1:0] val);
		logic [UNIT_W+CH_W-1:0] scaled;
		scaled = ({val, CH_W'(0)}) - (UNIT_W+CH_W)'(val);
		return scaled[FRAC_BITS+CH_W-1:FRAC_BITS];
	endfunction

	assign rdy3      = !valid_s3 || !rgb_stall;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign cls_ready = rdy1;

	assign prod_c = cls.v * cls.s;
	assign prod_x = c_s1 * w_s1;

	always_comb begin
		hi  = c_s2 + m_s2;
		mid = x_s2 + m_s2;
		lo  = m_s2;
		unique case (sec_s2)
			SEC_RY:  begin r_val = hi;  g_val = mid; b_val = lo;  end
			SEC_YG:  begin r_val = mid; g_val = hi;  b_val = lo;  end
			SEC_GC:  begin r_val = lo;  g_val = hi;  b_val = mid; end
			SEC_CB:  begin r_val = lo;  g_val = mid; b_val = hi;  end
			SEC_BM:  begin r_val = mid; g_val = lo;  b_val = hi;  end
			default: begin r_val = hi;  g_val = lo;  b_val = mid; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= cls_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && cls_valid) begin
			c_s1   <= prod_c[FRAC_BITS+UNIT_W-1:FRAC_BITS];
			w_s1   <= cls.w;
			v_s1   <= cls.v;
			sec_s1 <= cls.sector;
		end
		if (rdy2 && valid_s1) begin
			x_s2   <= prod_x[FRAC_BITS+UNIT_W-1:FRAC_BITS];
			m_s2   <= v_s1 - c_s1;
			c_s2   <= c_s1;
			sec_s2 <= sec_s1;
		end
		if (rdy3 && valid_s2) begin
			rgb_s3.red   <= to_byte(r_val);
			rgb_s3.green <= to_byte(g_val);
			rgb_s3.blue  <= to_byte(b_val);
		end
	end

	assign rgb       = rgb_s3;
	assign rgb_valid = valid_s3;

endmodule

FILE: design/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: fixed point hsv to 8-bit rgb conversion
// Takes one hue, saturation, value request per clock while hsv_stall is low
// and returns one rgb result per request. Inputs use 16 fraction bits; hue
// is folded into [0, 1) with a hue of exactly one giving red, saturation and
// value clamp at one. Throughput is one request per cycle while no stall
// holds the flow; a result is presented once its request has passed the
// front register, then the queue, then the three back stages, the first two
// back stages holding one 17x17 multiply each. The queue of QUEUE_DEPTH
// entries lets the front keep accepting while the result side stalls, until
// the queue is full.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
	parameter int QUEUE_DEPTH = h2r_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hsv_valid,
	output logic          hsv_stall,
	input  h2r_pkg::hsv_t hsv,
	output logic          rgb_valid,
	input  logic          rgb_stall,
	output h2r_pkg::rgb_t rgb
);
	import h2r_pkg::*;

	cls_t front_cls;
	cls_t queue_cls;
	logic front_valid;
	logic front_ready;
	logic queue_valid;
	logic back_ready;

	h2r_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv       (hsv),
		.cls       (front_cls),
		.cls_valid (front_valid),
		.cls_ready (front_ready)
	);

	h2r_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (front_cls),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_data  (queue_cls),
		.rd_valid (queue_valid),
		.rd_ready (back_ready)
	);

	h2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (queue_cls),
		.cls_valid (queue_valid),
		.cls_ready (back_ready),
		.rgb       (rgb),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall)
	);

endmodule
